// File: src/adc_ti_pkg.sv
// ---------------------------------------------------------------------------
// adc_ti_pkg : shared types and constants of the ADC table interpolator
// Payload structs, table geometry, command codes and the control/status
// bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package adc_ti_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int SAMPLE_BITS = 12;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	// Field widths fixed by the interface
	localparam int TEMP_W  = 16;
	localparam int INDEX_W = 6;
	localparam int SEG_W   = 6;
	localparam int CFG_W   = 7;

	// entries_used reset value
	localparam logic [CFG_W-1:0] ENTRIES_RESET = 7'd64;

	// Comparison widths for clamping the entry count and checking write indexes
	localparam int LIM_W = (CFG_W > ADDR_W + 1) ? CFG_W : ADDR_W + 1;
	localparam int WI_W  = (INDEX_W > ADDR_W + 1) ? INDEX_W : ADDR_W + 1;

	// Arithmetic widths
	localparam int DIFF_W = TEMP_W + 1;
	localparam int MULB_W = SAMPLE_BITS + 1;
	localparam int PROD_W = DIFF_W + MULB_W;
	localparam int NUM_W  = PROD_W + 1;

	// Divider: the quotient magnitude never exceeds 2^15, so 16 steps suffice
	localparam int DIV_STEPS = TEMP_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);

	// Item command codes
	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_CONVERT = 1'b1;

	// Input transaction
	typedef struct packed {
		logic                          cmd;
		logic [INDEX_W-1:0]            entry_index;
		logic [SAMPLE_BITS-1:0]        entry_sample;
		logic signed [TEMP_W-1:0]      entry_temp;
		logic [SAMPLE_BITS-1:0]        sample;
	} item_t;

	// Output transaction
	typedef struct packed {
		logic signed [TEMP_W-1:0]      temperature;
		logic                          exact_hit;
		logic                          out_of_range;
		logic [SEG_W-1:0]              segment;
	} result_t;

	// One calibration table entry as held in RAM
	typedef struct packed {
		logic [SAMPLE_BITS-1:0]        sample;
		logic signed [TEMP_W-1:0]      temp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Controller to datapath commands
	typedef struct packed {
		logic wr_entry;    // store the input entry in the table
		logic load_conv;   // latch sample and entry count, rewind the scan
		logic advance;     // move the read pointer on by one entry
		logic keep_prev;   // remember the entry just read as the lower entry
		logic capture;     // latch the outcome and interpolation operands
		logic mul_en;      // register a product
		logic mul_sel;     // 0: tlo * d, 1: (thi - tlo) * (x - xlo)
		logic acc_init;    // accumulator takes the product register
		logic acc_add;     // accumulator adds the product register
		logic div_load;    // load the divider from the accumulator
		logic div_step;    // one restoring division step
		logic div_end;     // apply the sign to the quotient
		logic out_load;    // move the finished answer to the output register
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic found;       // scan stops at the entry now on the read port
		logic interp;      // that stop needs interpolation
		logic div_last;    // divider is on its final step
	} dp_status_t;

endpackage

// File: src/adc_ti_ram.sv
// ---------------------------------------------------------------------------
// adc_ti_ram : generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ---------------------------------------------------------------------------
module adc_ti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/adc_ti_dp.sv
// ---------------------------------------------------------------------------
// adc_ti_dp : datapath of the ADC table interpolator
// Calibration table RAM, scan pointer, shared multiplier, accumulator,
// restoring divider and the output register.
// ---------------------------------------------------------------------------
module adc_ti_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  adc_ti_pkg::item_t            item,
	input  logic                         entries_used_we,
	input  logic [adc_ti_pkg::CFG_W-1:0] entries_used,
	input  adc_ti_pkg::ctrl_cmd_t        cmd,
	output adc_ti_pkg::dp_status_t       status,
	output adc_ti_pkg::result_t          result
);

	localparam int SB  = adc_ti_pkg::SAMPLE_BITS;
	localparam int AW  = adc_ti_pkg::ADDR_W;
	localparam int TW  = adc_ti_pkg::TEMP_W;

	logic [adc_ti_pkg::CFG_W-1:0]          entries_used_q;
	logic [SB-1:0]                         x_q;
	logic [AW-1:0]                         last_q;
	logic [AW-1:0]                         addr_q;
	logic [AW-1:0]                         cur_q;
	adc_ti_pkg::entry_t                    prev_q;
	logic signed [TW-1:0]                  res_temp_q;
	logic                                  exact_q;
	logic                                  oor_q;
	logic [adc_ti_pkg::SEG_W-1:0]          seg_q;
	logic [SB-1:0]                         d_q;
	logic [SB-1:0]                         dx_q;
	logic signed [adc_ti_pkg::DIFF_W-1:0]  diff_q;
	logic signed [adc_ti_pkg::PROD_W-1:0]  mul_q;
	logic signed [adc_ti_pkg::NUM_W-1:0]   acc_q;
	logic [SB-1:0]                         rem_q;
	logic [TW-1:0]                         quo_q;
	logic                                  neg_q;
	logic [adc_ti_pkg::DCNT_W-1:0]         div_cnt_q;
	adc_ti_pkg::result_t                   result_q;

	logic [adc_ti_pkg::ENTRY_W-1:0]        ram_rdata;
	adc_ti_pkg::entry_t                    rd_entry;
	adc_ti_pkg::entry_t                    wr_entry;
	logic                                  wr_ok;
	logic [adc_ti_pkg::LIM_W-1:0]          n_ext;
	logic [AW-1:0]                         last_d;
	logic                                  hit;
	logic                                  eq;
	logic                                  cur_zero;
	logic                                  at_last;
	logic signed [adc_ti_pkg::DIFF_W-1:0]  mul_a;
	logic signed [adc_ti_pkg::MULB_W-1:0]  mul_b;
	logic [adc_ti_pkg::NUM_W-1:0]          acc_mag;
	logic [SB:0]                           div_trial;
	logic [SB:0]                           div_d;
	logic                                  div_ge;

	// Entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_used_q <= adc_ti_pkg::ENTRIES_RESET;
		end else if (entries_used_we) begin
			entries_used_q <= entries_used;
		end
	end

	// Calibration table
	assign wr_entry.sample = item.entry_sample;
	assign wr_entry.temp   = item.entry_temp;
	assign wr_ok = adc_ti_pkg::WI_W'(item.entry_index)
		< adc_ti_pkg::WI_W'(adc_ti_pkg::TABLE_DEPTH);

	adc_ti_ram #(
		.WIDTH(adc_ti_pkg::ENTRY_W),
		.DEPTH(adc_ti_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.wr_entry & wr_ok),
		.waddr (AW'(item.entry_index)),
		.wdata (wr_entry),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign rd_entry = adc_ti_pkg::entry_t'(ram_rdata);

	// Index of the last entry in use, count clamped to 2..TABLE_DEPTH
	always_comb begin
		n_ext = adc_ti_pkg::LIM_W'(entries_used_q);
		if (n_ext < adc_ti_pkg::LIM_W'(2)) begin
			last_d = AW'(1);
		end else if (n_ext > adc_ti_pkg::LIM_W'(adc_ti_pkg::TABLE_DEPTH)) begin
			last_d = AW'(adc_ti_pkg::TABLE_DEPTH - 1);
		end else begin
			last_d = AW'(n_ext - adc_ti_pkg::LIM_W'(1));
		end
	end

	// Scan pointer: addr_q feeds the RAM, cur_q names the entry on its output
	always_ff @(posedge clk) begin
		if (cmd.load_conv) begin
			x_q    <= item.sample;
			last_q <= last_d;
			addr_q <= '0;
		end else if (cmd.advance) begin
			cur_q  <= addr_q;
			addr_q <= addr_q + AW'(1);
		end
		if (cmd.keep_prev) begin
			prev_q <= rd_entry;
		end
	end

	// Classification of the entry on the read port
	assign hit      = rd_entry.sample >= x_q;
	assign eq       = rd_entry.sample == x_q;
	assign cur_zero = cur_q == '0;
	assign at_last  = cur_q == last_q;

	assign status.found    = hit | at_last;
	assign status.interp   = hit & ~eq & ~cur_zero;
	assign status.div_last = div_cnt_q == adc_ti_pkg::DIV_LAST;

	// Outcome and interpolation operands
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_temp_q <= rd_entry.temp;
			exact_q    <= hit & eq;
			oor_q      <= ~hit | (~eq & cur_zero);
			seg_q      <= adc_ti_pkg::SEG_W'(cur_q);
			d_q        <= rd_entry.sample - prev_q.sample;
			dx_q       <= x_q - prev_q.sample;
			diff_q     <= {rd_entry.temp[TW-1], rd_entry.temp}
				- {prev_q.temp[TW-1], prev_q.temp};
		end else if (cmd.div_end) begin
			res_temp_q <= neg_q ? -quo_q : quo_q;
		end
	end

	// Shared multiplier, registered
	always_comb begin
		if (cmd.mul_sel) begin
			mul_a = diff_q;
			mul_b = {1'b0, dx_q};
		end else begin
			mul_a = {prev_q.temp[TW-1], prev_q.temp};
			mul_b = {1'b0, d_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			mul_q <= mul_a * mul_b;
		end
	end

	// Numerator accumulator
	always_ff @(posedge clk) begin
		if (cmd.acc_init) begin
			acc_q <= {mul_q[adc_ti_pkg::PROD_W-1], mul_q};
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + {mul_q[adc_ti_pkg::PROD_W-1], mul_q};
		end
	end

	// Restoring divider on the magnitude, one quotient bit per step
	assign acc_mag   = acc_q[adc_ti_pkg::NUM_W-1] ? -acc_q : acc_q;
	assign div_trial = {rem_q, quo_q[TW-1]};
	assign div_d     = {1'b0, d_q};
	assign div_ge    = div_trial >= div_d;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			neg_q     <= acc_q[adc_ti_pkg::NUM_W-1];
			rem_q     <= acc_mag[SB+TW-1:TW];
			quo_q     <= acc_mag[TW-1:0];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= div_ge ? SB'(div_trial - div_d) : div_trial[SB-1:0];
			quo_q     <= {quo_q[TW-2:0], div_ge};
			div_cnt_q <= div_cnt_q + adc_ti_pkg::DCNT_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.temperature  <= res_temp_q;
			result_q.exact_hit    <= exact_q;
			result_q.out_of_range <= oor_q;
			result_q.segment      <= seg_q;
		end
	end

	assign result = result_q;

endmodule

// File: src/adc_ti_ctrl.sv
// ---------------------------------------------------------------------------
// adc_ti_ctrl : controller of the ADC table interpolator
// Sequences table writes, the entry scan, multiply-accumulate, division
// and the hand-over of each result to the output channel.
// ---------------------------------------------------------------------------
module adc_ti_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_cmd,
	output logic                   item_stall,
	output logic                   result_valid,
	input  logic                   result_stall,
	input  adc_ti_pkg::dp_status_t status,
	output adc_ti_pkg::ctrl_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_MUL0  = 4'd3;
	localparam logic [3:0] S_MUL1  = 4'd4;
	localparam logic [3:0] S_ACC   = 4'd5;
	localparam logic [3:0] S_DLOAD = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_DEND  = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       result_valid_q;
	logic       accept;
	logic       out_free;

	assign accept     = item_valid & (state_q == S_IDLE);
	assign item_stall = state_q != S_IDLE;
	assign out_free   = ~result_valid_q | ~result_stall;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item_cmd == adc_ti_pkg::CMD_CONVERT) begin
						cmd.load_conv = 1'b1;
						state_d       = S_START;
					end else begin
						cmd.wr_entry = 1'b1;
					end
				end
			end
			S_START: begin
				cmd.advance = 1'b1;
				state_d     = S_SCAN;
			end
			S_SCAN: begin
				if (status.found) begin
					cmd.capture = 1'b1;
					state_d     = status.interp ? S_MUL0 : S_FIN;
				end else begin
					cmd.advance   = 1'b1;
					cmd.keep_prev = 1'b1;
				end
			end
			S_MUL0: begin
				cmd.mul_en = 1'b1;
				state_d    = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = 1'b1;
				cmd.acc_init = 1'b1;
				state_d      = S_ACC;
			end
			S_ACC: begin
				cmd.acc_add = 1'b1;
				state_d     = S_DLOAD;
			end
			S_DLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_DEND;
				end
			end
			S_DEND: begin
				cmd.div_end = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				// wait until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid: set on load, cleared once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (~result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

endmodule

// File: src/adc_table_interpolator.sv
// A convert result is valid once the scan finds its entry and, if needed, the
// interpolation multiplies, accumulates and divides. Throughput: one item at a
// time; writes are taken back to back, a convert holds off the next item until
// its result is loaded, longer while the previous result waits; the scan reads
// one entry per cycle, the divider takes 16 steps.
// Reset clears control state and sets entries_used to 64; table stays undefined.
// ---------------------------------------------------------------------------
// adc_table_interpolator : top level of the ADC table interpolator
// Converts raw converter samples to temperature by piecewise linear
// interpolation through a loaded calibration table.
// ---------------------------------------------------------------------------
module adc_table_interpolator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  adc_ti_pkg::item_t            item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output adc_ti_pkg::result_t          result,
	input  logic                         entries_used_we,
	input  logic [adc_ti_pkg::CFG_W-1:0] entries_used
);

	adc_ti_pkg::ctrl_cmd_t  cmd;
	adc_ti_pkg::dp_status_t status;

	// Controller
	adc_ti_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_cmd     (item.cmd),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// Datapath
	adc_ti_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item),
		.entries_used_we (entries_used_we),
		.entries_used    (entries_used),
		.cmd             (cmd),
		.status          (status),
		.result          (result)
	);

endmodule

// File: test/adc_table_interpolator_checker.sv
// ---------------------------------------------------------------------------
// adc_table_interpolator_checker : scoreboard for the ADC table interpolator
// Watches the item, result and register ports and keeps its own copy of the
// calibration table and entry count. It predicts every conversion and
// compares each result transaction field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module adc_table_interpolator_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_stall,
	input  adc_ti_pkg::item_t            item,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  adc_ti_pkg::result_t          result,
	input  logic                         entries_used_we,
	input  logic [adc_ti_pkg::CFG_W-1:0] entries_used,
	output int                           mismatches,
	output int                           outstanding,
	output int                           checked,
	output int                           exact_seen,
	output int                           clamped_seen
);
	import adc_ti_pkg::*;

	// Shadow calibration table and entry count
	logic [SAMPLE_BITS-1:0]   cal_sample [TABLE_DEPTH];
	logic signed [TEMP_W-1:0] cal_temp   [TABLE_DEPTH];
	logic [CFG_W-1:0]         used_reg = ENTRIES_RESET;

	// Predicted readings waiting for their result transaction
	result_t                  predicted_readings [$];
	result_t                  want;
	int                       n_fail    = 0;
	int                       n_checked = 0;
	int                       n_exact   = 0;
	int                       n_clamped = 0;

	// Piecewise linear conversion of one sample through the shadow table
	function automatic result_t interpolate_reading(input logic [SAMPLE_BITS-1:0] x);
		int      n;
		int      i;
		longint  tlo;
		longint  thi;
		longint  xlo;
		longint  d;
		longint  num;
		result_t r;
		n = int'(used_reg);
		if (n < 2) n = 2;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		// first entry in use at or above the sample
		i = 0;
		while (i < n && cal_sample[i] < x) i++;
		r = '0;
		if (i >= n) begin
			// above the last entry in use: clamp
			r.temperature  = cal_temp[n-1];
			r.out_of_range = 1'b1;
			r.segment      = SEG_W'(n - 1);
		end else if (cal_sample[i] == x) begin
			r.temperature = cal_temp[i];
			r.exact_hit   = 1'b1;
			r.segment     = SEG_W'(i);
		end else if (i == 0) begin
			// below entry 0: clamp
			r.temperature  = cal_temp[0];
			r.out_of_range = 1'b1;
			r.segment      = '0;
		end else begin
			// divisor is positive: lower entry below x, found entry above it
			tlo = cal_temp[i-1];
			thi = cal_temp[i];
			xlo = longint'(cal_sample[i-1]);
			d   = longint'(cal_sample[i]) - xlo;
			num = tlo * d + (thi - tlo) * (longint'(x) - xlo);
			r.temperature = TEMP_W'(num / d);
			r.segment     = SEG_W'(i);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[checker] %s", msg);
		n_fail++;
	endtask

	// Channel monitor: register write, result check, then item prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_reg = ENTRIES_RESET;
			predicted_readings.delete();
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				cal_sample[k] = '0;
				cal_temp[k]   = '0;
			end
		end else begin
			if (entries_used_we) used_reg = entries_used;

			if (result_valid && !result_stall) begin
				if (predicted_readings.size() == 0) begin
					report_mismatch($sformatf("result with nothing outstanding: temperature %0d",
						result.temperature));
				end else begin
					want = predicted_readings.pop_front();
					n_checked++;
					if (want.exact_hit) n_exact++;
					if (want.out_of_range) n_clamped++;
					if (result.temperature !== want.temperature)
						report_mismatch($sformatf("conversion %0d: temperature %0d, expected %0d",
							n_checked, result.temperature, want.temperature));
					if (result.exact_hit !== want.exact_hit)
						report_mismatch($sformatf("conversion %0d: exact_hit %b, expected %b",
							n_checked, result.exact_hit, want.exact_hit));
					if (result.out_of_range !== want.out_of_range)
						report_mismatch($sformatf("conversion %0d: out_of_range %b, expected %b",
							n_checked, result.out_of_range, want.out_of_range));
					if (result.segment !== want.segment)
						report_mismatch($sformatf("conversion %0d: segment %0d, expected %0d",
							n_checked, result.segment, want.segment));
				end
			end

			if (item_valid && !item_stall) begin
				if (item.cmd == CMD_WRITE) begin
					cal_sample[item.entry_index] = item.entry_sample;
					cal_temp[item.entry_index]   = item.entry_temp;
				end else begin
					predicted_readings.push_back(interpolate_reading(item.sample));
				end
			end
		end
		// published after the edge so the stimulus never races the update
		outstanding  <= predicted_readings.size();
		mismatches   <= n_fail;
		checked      <= n_checked;
		exact_seen   <= n_exact;
		clamped_seen <= n_clamped;
	end

endmodule

// File: test/adc_table_interpolator_tb.sv
// ---------------------------------------------------------------------------
// adc_table_interpolator_tb : testbench top for the ADC table interpolator
// Loads calibration tables of several shapes, runs directed conversions at
// the table edges and then random traffic under a range of entry counts,
// with random gaps on the item side and random stalls on the result side.
// ---------------------------------------------------------------------------
module adc_table_interpolator_tb;
	import adc_ti_pkg::*;

	localparam int IDLE_LIMIT    = 3000;  // cycles without any transaction
	localparam int SETTLE_CYCLES = 100;   // beyond the longest conversion
	localparam int PHASE_ITEMS   = 130;
	localparam int MAX_SAMPLE    = (1 << SAMPLE_BITS) - 1;

	typedef enum int {
		SHAPE_SPREAD,
		SHAPE_ENDS,
		SHAPE_DENSE,
		SHAPE_SHUFFLED,
		SHAPE_PLATEAU
	} table_shape_t;

	logic             clk             = 1'b0;
	logic             arst_n          = 1'b0;
	logic             item_valid      = 1'b0;
	logic             item_stall;
	item_t            item            = '0;
	logic             result_valid;
	logic             result_stall    = 1'b0;
	result_t          result;
	logic             entries_used_we = 1'b0;
	logic [CFG_W-1:0] entries_used    = ENTRIES_RESET;

	int mismatches;
	int outstanding;
	int checked;
	int exact_seen;
	int clamped_seen;

	// Sample values loaded so far, used to aim conversions at the table
	logic [SAMPLE_BITS-1:0] loaded_sample [TABLE_DEPTH];
	int n_live        = TABLE_DEPTH;
	bit no_gaps       = 1'b0;
	int settings_used = 0;
	int writes_sent   = 0;
	int idle_cycles   = 0;
	int stall_left    = 0;

	always #5 clk = ~clk;

	adc_table_interpolator i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.item            (item),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result          (result),
		.entries_used_we (entries_used_we),
		.entries_used    (entries_used)
	);

	adc_table_interpolator_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.item            (item),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result          (result),
		.entries_used_we (entries_used_we),
		.entries_used    (entries_used),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.checked         (checked),
		.exact_seen      (exact_seen),
		.clamped_seen    (clamped_seen)
	);

	// Result-side back-pressure: short runs, a few long stalls, quiet stretches
	always @(posedge clk) begin : stall_gen
		int pick;
		if (stall_left > 0) begin
			stall_left--;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				result_stall <= 1'b0;
				stall_left = $urandom_range(0, 7);
			end else if (pick < 85) begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(0, 2);
			end else if (pick < 95) begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(9, 59);
			end else begin
				result_stall <= 1'b0;
				stall_left = $urandom_range(100, 400);
			end
		end
	end

	// Watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || entries_used_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction", idle_cycles);
			$display("[adc_table_interpolator] ERROR");
			$finish;
		end
	end

	// Sender gap: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic int pick_temp();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return -32768;
		if (r == 1) return 32767;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// Conversion target: exact entries, neighbours, inside segments, edges
	function automatic int pick_sample();
		int r;
		int j;
		int lo;
		int hi;
		r  = $urandom_range(0, 99);
		j  = $urandom_range(0, n_live - 1);
		lo = (j > 0) ? int'(loaded_sample[j-1]) : 0;
		hi = int'(loaded_sample[j]);
		if (r < 25) return hi;
		if (r < 40) return (hi + 1) % (MAX_SAMPLE + 1);
		if (r < 55) return (hi + MAX_SAMPLE) % (MAX_SAMPLE + 1);
		if (r < 75 && hi > lo) return $urandom_range(lo, hi);
		if (r < 80) return 0;
		if (r < 85) return MAX_SAMPLE;
		return $urandom_range(0, MAX_SAMPLE);
	endfunction

	// One item transaction; valid stays high into the next item when no gap
	task automatic send_item(input item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic write_entry(input int idx, input int s, input int t);
		item_t it;
		it.cmd          = CMD_WRITE;
		it.entry_index  = INDEX_W'(idx);
		it.entry_sample = SAMPLE_BITS'(s);
		it.entry_temp   = TEMP_W'(t);
		it.sample       = SAMPLE_BITS'($urandom);
		loaded_sample[idx] = SAMPLE_BITS'(s);
		writes_sent++;
		send_item(it);
	endtask

	task automatic request_conversion(input int x);
		item_t it;
		it.cmd          = CMD_CONVERT;
		it.entry_index  = INDEX_W'($urandom);
		it.entry_sample = SAMPLE_BITS'($urandom);
		it.entry_temp   = TEMP_W'($urandom);
		it.sample       = SAMPLE_BITS'(x);
		send_item(it);
	endtask

	// Stop sending, wait for every outstanding result, then let writes settle
	task automatic drain_pipeline();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_entries_used(input int v);
		drain_pipeline();
		entries_used_we <= 1'b1;
		entries_used    <= CFG_W'(v);
		@(posedge clk);
		entries_used_we <= 1'b0;
		entries_used    <= CFG_W'($urandom);  // ignored without the enable
		n_live = (v < 2) ? 2 : (v > TABLE_DEPTH) ? TABLE_DEPTH : v;
		settings_used++;
	endtask

	// Rewrite every entry; the entries in use follow the requested shape
	task automatic load_table(input table_shape_t shape);
		int vals [TABLE_DEPTH];
		int base;
		int span;
		int v;
		case (shape)
			SHAPE_DENSE: begin
				base = $urandom_range(0, MAX_SAMPLE - 3 * n_live);
				span = 2;
			end
			SHAPE_ENDS: begin
				base = 0;
				span = (MAX_SAMPLE - n_live) / n_live;
			end
			default: begin
				base = $urandom_range(0, 200);
				span = (MAX_SAMPLE - 200 - n_live) / n_live;
			end
		endcase
		v = base;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (i >= n_live) begin
				vals[i] = $urandom_range(0, MAX_SAMPLE);
			end else begin
				if (i > 0) begin
					if (shape == SHAPE_PLATEAU && $urandom_range(0, 1) == 0)
						v = v;  // repeated sample value
					else
						v = v + 1 + $urandom_range(0, span);
				end
				vals[i] = v;
			end
		end
		if (shape == SHAPE_ENDS) vals[n_live-1] = MAX_SAMPLE;
		// break the ordering at a few places
		if (shape == SHAPE_SHUFFLED) begin
			for (int k = 0; k <= n_live / 4; k++)
				vals[$urandom_range(0, n_live - 1)] = $urandom_range(0, MAX_SAMPLE);
		end
		for (int i = 0; i < TABLE_DEPTH; i++)
			write_entry(i, vals[i], pick_temp());
	endtask

	task automatic run_phase(input int setting, input table_shape_t shape);
		int s;
		set_entries_used(setting);
		load_table(shape);
		for (int k = 0; k < PHASE_ITEMS; k++) begin
			if (k % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 6) begin
				// stray entry rewrite mid-stream
				s = ($urandom_range(0, 1) == 0) ? pick_sample() : $urandom_range(0, MAX_SAMPLE);
				write_entry($urandom_range(0, TABLE_DEPTH - 1), s, pick_temp());
			end else begin
				request_conversion(pick_sample());
			end
		end
		no_gaps = 1'b0;
	endtask

	// Stimulus and verdict
	initial begin
		int settings [10];
		settings    = '{64, 2, 0, 1, 127, 65, 33, 8, 0, 0};
		settings[8] = $urandom_range(0, 127);
		settings[9] = $urandom_range(2, 64);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset entry count: full table with both sample extremes
		load_table(SHAPE_ENDS);
		request_conversion(0);
		request_conversion(MAX_SAMPLE);
		request_conversion(loaded_sample[31]);
		request_conversion(loaded_sample[31] + 1);

		// four-entry table with the temperature extremes
		set_entries_used(4);
		write_entry(0, 100, -32768);
		write_entry(1, 2000, 32767);
		write_entry(2, 2001, 0);
		write_entry(3, 4000, -100);
		request_conversion(0);           // below the table
		request_conversion(99);
		request_conversion(100);         // exact on the first entry
		request_conversion(101);         // steep rising segment
		request_conversion(1999);
		request_conversion(2000);
		request_conversion(2001);        // exact after a unit-width segment
		request_conversion(3000);        // negative quotient truncates toward zero
		request_conversion(3999);
		request_conversion(4000);        // exact on the last entry
		request_conversion(4001);        // above the table
		request_conversion(MAX_SAMPLE);

		// random traffic over the register settings and table shapes
		for (int p = 0; p < 10; p++)
			run_phase(settings[p], table_shape_t'(p % 5));

		drain_pipeline();
		$display("covered %0d conversions: %0d exact, %0d clamped, %0d interpolated",
			checked, exact_seen, clamped_seen, checked - exact_seen - clamped_seen);
		$display("with %0d table writes over %0d entry-count settings, %0d mismatches",
			writes_sent, settings_used, mismatches);
		if (mismatches == 0)
			$display("[adc_table_interpolator] OK");
		else
			$display("[adc_table_interpolator] ERROR");
		$finish;
	end

endmodule
